### sv/sorted_timer_bank_defines.svh
// assertion macros shared by the sorted timer bank
`ifndef SORTED_TIMER_BANK_DEFINES_SVH
`define SORTED_TIMER_BANK_DEFINES_SVH

// same-cycle implication, checked outside reset
`define STB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted timer bank check failed");

// next-cycle implication, checked outside reset
`define STB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted timer bank check failed");

`endif

### sv/stb_pkg.sv
// types, codes and helpers of the sorted timer bank
`timescale 1ns / 1ps
package stb_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    // command codes
    localparam logic [2:0] FUNC_CREATE = 3'd0;
    localparam logic [2:0] FUNC_START  = 3'd1;
    localparam logic [2:0] FUNC_STOP   = 3'd2;
    localparam logic [2:0] FUNC_DELETE = 3'd3;
    localparam logic [2:0] FUNC_SETIV  = 3'd4;
    localparam logic [2:0] FUNC_QUERY  = 3'd5;
    localparam logic [2:0] FUNC_TICK   = 3'd6;
    localparam logic [2:0] FUNC_NONE   = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd1;
    localparam logic [2:0] ST_BAD_STATE  = 3'd2;
    localparam logic [2:0] ST_RANGE      = 3'd3;
    localparam logic [2:0] ST_NO_SLOT    = 3'd4;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_CREATE   = 5'd2;
    localparam logic [4:0] OP_REPLY    = 5'd3;
    localparam logic [4:0] OP_RD_WSLOT = 5'd4;
    localparam logic [4:0] OP_QUERY    = 5'd5;
    localparam logic [4:0] OP_POS_CLR  = 5'd6;
    localparam logic [4:0] OP_POS_INC  = 5'd7;
    localparam logic [4:0] OP_RM_SHIFT = 5'd8;
    localparam logic [4:0] OP_RD_PER   = 5'd9;
    localparam logic [4:0] OP_SET_WAKE = 5'd10;
    localparam logic [4:0] OP_RD_LIST  = 5'd11;
    localparam logic [4:0] OP_INSERT   = 5'd12;
    localparam logic [4:0] OP_TICK     = 5'd13;
    localparam logic [4:0] OP_RD_HEAD  = 5'd14;
    localparam logic [4:0] OP_POP      = 5'd15;
    localparam logic [4:0] OP_REPORT   = 5'd16;
    localparam logic [4:0] OP_CLR_RUN  = 5'd17;
    localparam logic [4:0] OP_DEL      = 5'd18;
    localparam logic [4:0] OP_WR_PER   = 5'd19;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  handle;
        logic        mode;
        logic [31:0] interval;
    } t_in;

    typedef struct packed {
        logic        reply_kind;
        logic [2:0]  status;
        logic [3:0]  result_handle;
        logic [31:0] remaining;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] status;
        logic       give_handle;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       h_ok;
        logic       used;
        logic       running;
        logic       iv_bad;
        logic       free_ok;
        logic       cnt_zero;
        logic       pos_end;
        logic       pos_match;
        logic       wake_after;
        logic       head_due;
        logic       dn_zero;
        logic       dq_auto;
        logic       out_free;
    } t_dp_stat;

    // wrapping difference a - b read as signed is above zero
    function automatic logic diff_pos(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

### sv/stb_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic [AW-1:0]    i_ra,
    output logic [WIDTH-1:0] o_rd
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;
endmodule

### sv/stb_ctrl.sv
// sequencer of the sorted timer bank
`timescale 1ns / 1ps
module stb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  stb_pkg::t_dp_stat i_stat,
    output stb_pkg::t_dp_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_RM     = 4'd2;
    localparam logic [3:0] S_POSTRM = 4'd3;
    localparam logic [3:0] S_RDPER  = 4'd4;
    localparam logic [3:0] S_SETW   = 4'd5;
    localparam logic [3:0] S_INS    = 4'd6;
    localparam logic [3:0] S_INSCMP = 4'd7;
    localparam logic [3:0] S_QCMP   = 4'd8;
    localparam logic [3:0] S_REPLY  = 4'd9;
    localparam logic [3:0] S_DRRD   = 4'd10;
    localparam logic [3:0] S_DRCMP  = 4'd11;
    localparam logic [3:0] S_AP     = 4'd12;

    logic [3:0] r_state, n_state;
    logic [2:0] r_st, n_st;
    logic [3:0] w_ins_done;

    // after an insert a tick goes back to its reports, a command replies
    assign w_ins_done = (i_stat.func == stb_pkg::FUNC_TICK) ? S_AP : S_REPLY;

    // next state and command
    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '{op: stb_pkg::OP_NONE, status: r_st, give_handle: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = stb_pkg::OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_st    = stb_pkg::ST_OK;
                n_state = S_REPLY;
                if (i_stat.func == stb_pkg::FUNC_CREATE) begin
                    if (i_stat.iv_bad) begin
                        n_st = stb_pkg::ST_RANGE;
                    end else if (!i_stat.free_ok) begin
                        n_st = stb_pkg::ST_NO_SLOT;
                    end else begin
                        o_cmd.op = stb_pkg::OP_CREATE;
                    end
                end else if (i_stat.func == stb_pkg::FUNC_TICK) begin
                    o_cmd.op = stb_pkg::OP_TICK;
                    n_state  = S_DRRD;
                end else if (i_stat.func == stb_pkg::FUNC_NONE) begin
                    n_state = S_IDLE;
                end else if (!i_stat.h_ok) begin
                    n_st = stb_pkg::ST_BAD_HANDLE;
                end else if (!i_stat.used) begin
                    n_st = stb_pkg::ST_BAD_STATE;
                end else begin
                    priority case (i_stat.func)
                        stb_pkg::FUNC_START: begin
                            if (i_stat.running) begin
                                o_cmd.op = stb_pkg::OP_POS_CLR;
                                n_state  = S_RM;
                            end else begin
                                n_state = S_RDPER;
                            end
                        end
                        stb_pkg::FUNC_STOP: begin
                            if (!i_stat.running) begin
                                n_st = stb_pkg::ST_BAD_STATE;
                            end else begin
                                o_cmd.op = stb_pkg::OP_POS_CLR;
                                n_state  = S_RM;
                            end
                        end
                        stb_pkg::FUNC_DELETE: begin
                            if (i_stat.running) begin
                                o_cmd.op = stb_pkg::OP_POS_CLR;
                                n_state  = S_RM;
                            end else begin
                                o_cmd.op = stb_pkg::OP_DEL;
                            end
                        end
                        stb_pkg::FUNC_SETIV: begin
                            if (i_stat.iv_bad) begin
                                n_st = stb_pkg::ST_RANGE;
                            end else if (i_stat.running) begin
                                o_cmd.op = stb_pkg::OP_POS_CLR;
                                n_state  = S_RM;
                            end else begin
                                o_cmd.op = stb_pkg::OP_WR_PER;
                            end
                        end
                        default: begin
                            if (!i_stat.running) begin
                                n_st = stb_pkg::ST_BAD_STATE;
                            end else begin
                                o_cmd.op = stb_pkg::OP_RD_WSLOT;
                                n_state  = S_QCMP;
                            end
                        end
                    endcase
                end
            end
            // walk the list until the addressed timer is found
            S_RM: begin
                if (i_stat.pos_end) begin
                    n_state = S_POSTRM;
                end else if (i_stat.pos_match) begin
                    o_cmd.op = stb_pkg::OP_RM_SHIFT;
                    n_state  = S_POSTRM;
                end else begin
                    o_cmd.op = stb_pkg::OP_POS_INC;
                end
            end
            S_POSTRM: begin
                priority case (i_stat.func)
                    stb_pkg::FUNC_START: n_state = S_RDPER;
                    stb_pkg::FUNC_STOP: begin
                        o_cmd.op = stb_pkg::OP_CLR_RUN;
                        n_state  = S_REPLY;
                    end
                    stb_pkg::FUNC_DELETE: begin
                        o_cmd.op = stb_pkg::OP_DEL;
                        n_state  = S_REPLY;
                    end
                    stb_pkg::FUNC_SETIV: begin
                        o_cmd.op = stb_pkg::OP_WR_PER;
                        n_state  = S_RDPER;
                    end
                    default: n_state = S_REPLY;
                endcase
            end
            S_RDPER: begin
                o_cmd.op = stb_pkg::OP_RD_PER;
                n_state  = S_SETW;
            end
            S_SETW: begin
                o_cmd.op = stb_pkg::OP_SET_WAKE;
                n_state  = S_INS;
            end
            // sorted insert: read each list entry in S_INS, compare it in S_INSCMP
            S_INS: begin
                if (i_stat.pos_end) begin
                    o_cmd.op = stb_pkg::OP_INSERT;
                    n_state  = w_ins_done;
                end else begin
                    o_cmd.op = stb_pkg::OP_RD_LIST;
                    n_state  = S_INSCMP;
                end
            end
            S_INSCMP: begin
                if (i_stat.wake_after) begin
                    o_cmd.op = stb_pkg::OP_INSERT;
                    n_state  = w_ins_done;
                end else begin
                    o_cmd.op = stb_pkg::OP_POS_INC;
                    n_state  = S_INS;
                end
            end
            S_QCMP: begin
                o_cmd.op = stb_pkg::OP_QUERY;
                n_state  = S_REPLY;
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.op          = stb_pkg::OP_REPLY;
                    o_cmd.give_handle = (i_stat.func == stb_pkg::FUNC_CREATE) &&
                                        (r_st == stb_pkg::ST_OK);
                    n_state           = S_IDLE;
                end
            end
            // take due timers off the head
            S_DRRD: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_AP;
                end else begin
                    o_cmd.op = stb_pkg::OP_RD_HEAD;
                    n_state  = S_DRCMP;
                end
            end
            S_DRCMP: begin
                if (i_stat.head_due) begin
                    o_cmd.op = stb_pkg::OP_POP;
                    n_state  = S_DRRD;
                end else begin
                    n_state = S_AP;
                end
            end
            // report each due timer and re-arm auto-reload ones
            S_AP: begin
                if (i_stat.dn_zero) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.op = stb_pkg::OP_REPORT;
                    n_state  = i_stat.dq_auto ? S_RDPER : S_AP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= stb_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
endmodule

### sv/stb_dp.sv
// datapath of the sorted timer bank: slots, order list, time and result register
`timescale 1ns / 1ps
module stb_dp #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
    localparam int CW = $clog2(NUM_TIMERS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stb_pkg::t_in      i_in_data,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output stb_pkg::t_out     o_out_data,
    input  stb_pkg::t_dp_cmd  i_cmd,
    output stb_pkg::t_dp_stat o_stat
);
    logic [31:0]           r_limit;
    logic [31:0]           r_time;
    logic [NUM_TIMERS-1:0] r_used;
    logic [NUM_TIMERS-1:0] r_run;
    logic [NUM_TIMERS-1:0] r_auto;
    logic [SW-1:0]         r_list [NUM_TIMERS];
    logic [SW-1:0]         r_dq   [NUM_TIMERS];
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_dn;
    logic [CW-1:0]         r_pos;
    logic [2:0]            r_func;
    logic [7:0]            r_h;
    logic                  r_mode;
    logic [31:0]           r_iv;
    logic [SW-1:0]         r_slot;
    logic [31:0]           r_w;
    logic [31:0]           r_rem;
    logic                  r_ovalid;
    stb_pkg::t_out         r_out;

    logic [SW-1:0] w_free;
    logic [SW-1:0] w_wake_ra;
    logic [SW-1:0] w_per_wa;
    logic [31:0]   w_per_wd;
    logic          w_per_we;
    logic [31:0]   w_wake_rd;
    logic [31:0]   w_per_rd;
    logic [31:0]   w_new_wake;
    logic          w_out_free;

    // lowest free slot
    always_comb begin
        w_free = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free = SW'(i);
            end
        end
    end

    // ram addressing
    always_comb begin
        unique case (i_cmd.op)
            stb_pkg::OP_RD_LIST: w_wake_ra = r_list[r_pos[SW-1:0]];
            stb_pkg::OP_RD_HEAD: w_wake_ra = r_list[0];
            default:             w_wake_ra = r_slot;
        endcase
    end

    assign w_per_we   = (i_cmd.op == stb_pkg::OP_CREATE) || (i_cmd.op == stb_pkg::OP_WR_PER);
    assign w_per_wa   = (i_cmd.op == stb_pkg::OP_CREATE) ? w_free : r_slot;
    assign w_per_wd   = r_iv;
    assign w_new_wake = r_time + w_per_rd;
    assign w_out_free = !r_ovalid || !i_out_stall;

    stb_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_wake_ram (
        .i_clk (i_clk),
        .i_we  (i_cmd.op == stb_pkg::OP_SET_WAKE),
        .i_wa  (r_slot),
        .i_wd  (w_new_wake),
        .i_ra  (w_wake_ra),
        .o_rd  (w_wake_rd)
    );

    stb_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_period_ram (
        .i_clk (i_clk),
        .i_we  (w_per_we),
        .i_wa  (w_per_wa),
        .i_wd  (w_per_wd),
        .i_ra  (r_slot),
        .o_rd  (w_per_rd)
    );

    // status towards the sequencer
    always_comb begin
        o_stat.func       = r_func;
        o_stat.h_ok       = {1'b0, r_h} < 9'(NUM_TIMERS);
        o_stat.used       = r_used[r_slot];
        o_stat.running    = r_run[r_slot];
        o_stat.iv_bad     = (r_iv == 32'd0) || (r_iv >= r_limit);
        o_stat.free_ok    = !(&r_used);
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.pos_end    = (r_pos == r_cnt);
        o_stat.pos_match  = (r_list[r_pos[SW-1:0]] == r_slot);
        o_stat.wake_after = stb_pkg::diff_pos(w_wake_rd, r_w);
        o_stat.head_due   = !stb_pkg::diff_pos(w_wake_rd, r_time);
        o_stat.dn_zero    = (r_dn == '0);
        o_stat.dq_auto    = r_auto[r_dq[0]];
        o_stat.out_free   = w_out_free;
    end

    // control state: time, flags, counts, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= '1;
            r_time   <= '0;
            r_used   <= '0;
            r_run    <= '0;
            r_cnt    <= '0;
            r_dn     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            unique case (i_cmd.op)
                stb_pkg::OP_TICK:     r_time <= r_time + 32'd1;
                stb_pkg::OP_CREATE: begin
                    r_used[w_free] <= 1'b1;
                    r_run[w_free]  <= 1'b0;
                end
                stb_pkg::OP_SET_WAKE: r_run[r_slot] <= 1'b1;
                stb_pkg::OP_CLR_RUN:  r_run[r_slot] <= 1'b0;
                stb_pkg::OP_DEL: begin
                    r_used[r_slot] <= 1'b0;
                    r_run[r_slot]  <= 1'b0;
                end
                stb_pkg::OP_RM_SHIFT: r_cnt <= r_cnt - CW'(1);
                stb_pkg::OP_INSERT:   r_cnt <= r_cnt + CW'(1);
                stb_pkg::OP_POP: begin
                    r_cnt <= r_cnt - CW'(1);
                    r_dn  <= r_dn + CW'(1);
                end
                stb_pkg::OP_REPORT: begin
                    r_dn           <= r_dn - CW'(1);
                    r_run[r_dq[0]] <= r_auto[r_dq[0]];
                end
                default: ;
            endcase
            if ((i_cmd.op == stb_pkg::OP_REPLY) || (i_cmd.op == stb_pkg::OP_REPORT)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload: latched command, list and due queue cells, result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            stb_pkg::OP_LOAD: begin
                r_func <= i_in_data.func;
                r_h    <= i_in_data.handle;
                r_mode <= i_in_data.mode;
                r_iv   <= i_in_data.interval;
                r_slot <= i_in_data.handle[SW-1:0];
                r_rem  <= '0;
            end
            stb_pkg::OP_CREATE: begin
                r_slot         <= w_free;
                r_auto[w_free] <= r_mode;
            end
            stb_pkg::OP_QUERY: begin
                r_rem <= stb_pkg::diff_pos(w_wake_rd, r_time) ? (w_wake_rd - r_time) : '0;
            end
            stb_pkg::OP_POS_CLR, stb_pkg::OP_TICK: r_pos <= '0;
            stb_pkg::OP_POS_INC: r_pos <= r_pos + CW'(1);
            stb_pkg::OP_SET_WAKE: begin
                r_w   <= w_new_wake;
                r_pos <= '0;
            end
            stb_pkg::OP_RM_SHIFT: begin
                for (int j = 0; j < NUM_TIMERS - 1; j++) begin
                    if (CW'(j) >= r_pos) begin
                        r_list[j] <= r_list[j+1];
                    end
                end
            end
            stb_pkg::OP_INSERT: begin
                for (int j = 1; j < NUM_TIMERS; j++) begin
                    if (CW'(j) > r_pos) begin
                        r_list[j] <= r_list[j-1];
                    end
                end
                r_list[r_pos[SW-1:0]] <= r_slot;
            end
            stb_pkg::OP_POP: begin
                for (int j = 0; j < NUM_TIMERS - 1; j++) begin
                    r_list[j] <= r_list[j+1];
                end
                r_dq[r_dn[SW-1:0]] <= r_list[0];
            end
            stb_pkg::OP_REPORT: begin
                for (int j = 0; j < NUM_TIMERS - 1; j++) begin
                    r_dq[j] <= r_dq[j+1];
                end
                r_slot <= r_dq[0];
                r_out  <= '{reply_kind: stb_pkg::KIND_EXPIRY, status: stb_pkg::ST_OK,
                            result_handle: 4'(r_dq[0]), remaining: 32'd0,
                            last: (r_dn == CW'(1))};
            end
            stb_pkg::OP_REPLY: begin
                r_out <= '{reply_kind: stb_pkg::KIND_REPLY, status: i_cmd.status,
                           result_handle: i_cmd.give_handle ? 4'(r_slot) : 4'd0,
                           remaining: r_rem, last: 1'b1};
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule

### sv/sorted_timer_bank.sv
// top level of the sorted timer bank
`timescale 1ns / 1ps
`include "sorted_timer_bank_defines.svh"
// Bank of NUM_TIMERS one-shot or auto-reload timers kept in a list sorted by
// wake time; one command or tick is taken at a time and the input stalls until
// all its results have gone into the output register. A slot command walks the
// list to take a running timer off it, and walks it again in the sorted insert
// when it is armed. A tick drains the due timers from the head, then reports
// each one and arms and inserts the auto-reload timers again. The time taken is
// set by the walk over the order list; the insert walk reads the wake-time
// memory once per entry. The wake and period memories need no clearing pass,
// so the block is ready straight out of reset.
module sorted_timer_bank #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  stb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output stb_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data
);
    stb_pkg::t_dp_cmd  w_cmd;
    stb_pkg::t_dp_stat w_stat;
    logic              w_reply;
    logic              w_report;
    logic              w_emit;

    stb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    stb_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    // result-producing commands
    assign w_reply  = (w_cmd.op == stb_pkg::OP_REPLY);
    assign w_report = (w_cmd.op == stb_pkg::OP_REPORT);
    assign w_emit   = w_reply || w_report;

    // results only go out when the output register can take them
    `STB_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, w_emit, w_stat.out_free)
    // an expiry report only with a due timer queued
    `STB_ASSERT_NOW(a_report_queued, i_clk, i_rst_n, w_report, !w_stat.dn_zero)
    // a command reply always closes its transfer group
    `STB_ASSERT_NEXT(a_reply_last, i_clk, i_rst_n, w_reply, o_out_valid && o_out_data.last)
endmodule
